/* rtl/core/glu_pkg.sv */
// glu_pkg: transaction payload types and shared constants for gcd_lcm_unit.
// No dependencies.
`timescale 1ns / 1ps

package glu_pkg;

   localparam int OPERAND_W         = 16;
   localparam int GCD_W             = 16;
   localparam int LCM_W             = 32;
   localparam int OPERAND_WIDTH_DEF = 16;

   typedef struct packed {
      logic [OPERAND_W-1:0] operand_a;
      logic [OPERAND_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [GCD_W-1:0] gcd_value;
      logic [LCM_W-1:0] lcm_value;
      logic             input_error;
   } rsp_type;

endpackage

/* rtl/core/gcd_lcm_unit_top.sv */
// gcd_lcm_unit_top: pipelined GCD (binary method) and LCM (divide, then multiply).
// Depends on glu_pkg.
`timescale 1ns / 1ps

// Usage
//   req_* : valid/ready input channel, one transaction carries operand_a and operand_b.
//   rsp_* : valid/ready result channel, one transaction per request, in request order:
//           gcd_value, lcm_value (low 32 bits) and input_error.
//   An operand of zero sets input_error and returns zero for both results.
// Stages: one load stage, 2*OPERAND_WIDTH binary GCD steps, one stage that
//   restores the common power of two, OPERAND_WIDTH restoring divide steps (a / gcd),
//   and the output register, which also takes the product (a / gcd) * b.
// Throughput: one transaction per cycle unless rsp_ready stalls the output; every
//   stage is a register with its own valid bit.
// Reset: synchronous, active high; clears all valid bits, so no response is
//   pending afterwards. Data registers are not reset.
// Back-pressure: when rsp_valid is high and rsp_ready low, the whole pipe holds
//   and req_ready drops; nothing is dropped or repeated. Bubbles in the pipe do
//   not squeeze out while stalled.
module gcd_lcm_unit_top
   import glu_pkg::*;
#(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int W  = OPERAND_WIDTH;
   localparam int KW = $clog2(W + 1);
   localparam int GS = 2 * W;    // GCD step stages
   localparam int DS = W;        // divide step stages

   typedef struct packed {
      logic          err;
      logic [W-1:0]  a;
      logic [W-1:0]  b;
      logic [W-1:0]  u;
      logic [W-1:0]  v;
      logic [KW-1:0] k;
   } gcd_st_type;

   typedef struct packed {
      logic         err;
      logic [W-1:0] b;
      logic [W-1:0] g;
      logic [W-1:0] num;
      logic [W-1:0] quo;
      logic [W-1:0] rem;
   } div_st_type;

   // One binary GCD step; holds once either value reaches zero.
   function automatic gcd_st_type gcd_step(input gcd_st_type s);
      gcd_st_type r;
      r = s;
      if (s.u != '0 && s.v != '0) begin
         if (!s.u[0] && !s.v[0]) begin
            r.u = s.u >> 1;
            r.v = s.v >> 1;
            r.k = s.k + 1'b1;
         end else if (!s.u[0]) begin
            r.u = s.u >> 1;
         end else if (!s.v[0]) begin
            r.v = s.v >> 1;
         end else if (s.u >= s.v) begin
            r.u = (s.u - s.v) >> 1;
         end else begin
            r.v = (s.v - s.u) >> 1;
         end
      end
      return r;
   endfunction

   // One restoring divide step, dividend bits taken MSB first.
   function automatic div_st_type div_step(input div_st_type s);
      div_st_type r;
      logic [W:0] cand;
      r    = s;
      cand = {s.rem, s.num[W-1]};
      r.num = s.num << 1;
      if (cand >= {1'b0, s.g}) begin
         cand  = cand - {1'b0, s.g};
         r.quo = {s.quo[W-2:0], 1'b1};
      end else begin
         r.quo = {s.quo[W-2:0], 1'b0};
      end
      r.rem = cand[W-1:0];
      return r;
   endfunction

   logic [W-1:0] in_a;
   logic [W-1:0] in_b;

   generate
      if (W <= OPERAND_W) begin : g_narrow
         assign in_a = req_payload.operand_a[W-1:0];
         assign in_b = req_payload.operand_b[W-1:0];
      end else begin : g_wide
         assign in_a = {{(W-OPERAND_W){1'b0}}, req_payload.operand_a};
         assign in_b = {{(W-OPERAND_W){1'b0}}, req_payload.operand_b};
      end
   endgenerate

   // Whole pipe advances together when the output register is free or drained.
   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   gcd_st_type gs_ff [0:GS];
   gcd_st_type gs_in [0:GS];
   logic       gv_ff [0:GS];
   div_st_type ds_ff [0:DS];
   div_st_type ds_in [0:DS];
   logic       dv_ff [0:DS];
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   logic [W-1:0] g_comb;
   logic [2*W-1:0] prod;

   always_comb begin
      gs_in[0].err = (in_a == '0) || (in_b == '0);
      gs_in[0].a   = in_a;
      gs_in[0].b   = in_b;
      gs_in[0].u   = in_a;
      gs_in[0].v   = in_b;
      gs_in[0].k   = '0;
      for (int i = 1; i <= GS; i++) begin
         gs_in[i] = gcd_step(gs_ff[i-1]);
      end
   end

   // Restore the shared power of two; divisor forced to one on error.
   assign g_comb = (gs_ff[GS].u | gs_ff[GS].v) << gs_ff[GS].k;

   always_comb begin
      ds_in[0].err = gs_ff[GS].err;
      ds_in[0].b   = gs_ff[GS].b;
      ds_in[0].g   = gs_ff[GS].err ? W'(1) : g_comb;
      ds_in[0].num = gs_ff[GS].a;
      ds_in[0].quo = '0;
      ds_in[0].rem = '0;
      for (int i = 1; i <= DS; i++) begin
         ds_in[i] = div_step(ds_ff[i-1]);
      end
   end

   assign prod = ds_ff[DS].quo * ds_ff[DS].b;

   generate
      if (2 * W >= LCM_W) begin : g_lcm_cut
         assign rsp_in.lcm_value = ds_ff[DS].err ? '0 : prod[LCM_W-1:0];
      end else begin : g_lcm_ext
         assign rsp_in.lcm_value = ds_ff[DS].err ? '0 :
                                   {{(LCM_W-2*W){1'b0}}, prod};
      end
      if (W >= GCD_W) begin : g_gcd_cut
         assign rsp_in.gcd_value = ds_ff[DS].err ? '0 : ds_ff[DS].g[GCD_W-1:0];
      end else begin : g_gcd_ext
         assign rsp_in.gcd_value = ds_ff[DS].err ? '0 :
                                   {{(GCD_W-W){1'b0}}, ds_ff[DS].g};
      end
   endgenerate
   assign rsp_in.input_error = ds_ff[DS].err;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= GS; i++) gv_ff[i] <= 1'b0;
         for (int i = 0; i <= DS; i++) dv_ff[i] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         gv_ff[0] <= req_valid;
         for (int i = 1; i <= GS; i++) gv_ff[i] <= gv_ff[i-1];
         dv_ff[0] <= gv_ff[GS];
         for (int i = 1; i <= DS; i++) dv_ff[i] <= dv_ff[i-1];
         rsp_valid_ff <= dv_ff[DS];
      end
   end

   // Data registers
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= GS; i++) gs_ff[i] <= gs_in[i];
         for (int i = 0; i <= DS; i++) ds_ff[i] <= ds_in[i];
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* rtl/core/glu_checker.sv */
// glu_checker: port-level assertions for gcd_lcm_unit_top, plus its bind.
// Depends on glu_pkg and gcd_lcm_unit_top.
`timescale 1ns / 1ps

module glu_checker
   import glu_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // error transactions carry zero results
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.input_error |->
         rsp_payload.gcd_value == '0 && rsp_payload.lcm_value == '0)
      else $error("error response with nonzero result");

   // an empty output stage never back-pressures the input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind gcd_lcm_unit_top glu_checker u_glu_checker (.*);

/* bench/gcd_lcm_checker.sv */
// gcd_lcm_checker: watches both channels of gcd_lcm_unit_top, predicts each result
// and compares it with what comes out. Depends on glu_pkg.
`timescale 1ns / 1ps

module gcd_lcm_checker
   import glu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      pending_count,
   output int      result_count
);

   rsp_type expected_results[$];

   function automatic rsp_type gcd_lcm_of(req_type r);
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] t;
      rsp_type     o;
      x = 64'(r.operand_a);
      y = 64'(r.operand_b);
      o = '0;
      if (x == 0 || y == 0) begin
         o.input_error = 1'b1;
      end else begin
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         o.gcd_value = x[GCD_W-1:0];
         t = (64'(r.operand_a) / x) * 64'(r.operand_b);
         o.lcm_value = t[LCM_W-1:0];
      end
      return o;
   endfunction

   initial begin
      fail_count = 0;
      result_count = 0;
   end

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      rsp_type want;
      int      errs;
      errs = 0;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_results.push_back(gcd_lcm_of(req_payload));
         if (rsp_valid && rsp_ready) begin
            result_count <= result_count + 1;
            if (expected_results.size() == 0) begin
               $error("result with nothing expected: %p", rsp_payload);
               errs++;
            end else begin
               want = expected_results.pop_front();
               if (want.gcd_value !== rsp_payload.gcd_value) begin
                  $error("gcd_value expected %0d got %0d", want.gcd_value,
                         rsp_payload.gcd_value);
                  errs++;
               end
               if (want.lcm_value !== rsp_payload.lcm_value) begin
                  $error("lcm_value expected %0d got %0d", want.lcm_value,
                         rsp_payload.lcm_value);
                  errs++;
               end
               if (want.input_error !== rsp_payload.input_error) begin
                  $error("input_error expected %0d got %0d", want.input_error,
                         rsp_payload.input_error);
                  errs++;
               end
            end
            // one update per edge, however many fields disagree
            if (errs != 0)
               fail_count <= fail_count + errs;
         end
      end
   end

endmodule

/* bench/testbench.sv */
// testbench: stimulus and verdict for gcd_lcm_unit_top; checking lives in
// gcd_lcm_checker. Depends on glu_pkg, gcd_lcm_unit_top and gcd_lcm_checker.
`timescale 1ns / 1ps

module testbench;
   import glu_pkg::*;

   localparam int LATENCY = 3 * OPERAND_WIDTH_DEF + 3;
   localparam int RANDOM_ITEMS = 1160;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;
   int      fail_count;
   int      pending_count;
   int      result_count;
   int      sent_count;
   int      error_items;

   // Idle knobs, one per side: percent chance of a gap per cycle.
   int      send_idle_pct;
   int      recv_idle_pct;
   bit      recv_hold;   // long hold-off of the result side

   gcd_lcm_unit_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   gcd_lcm_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .fail_count   (fail_count),
      .pending_count(pending_count),
      .result_count (result_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit for ~1300 items.
   initial begin
      #20ms;
      $display("timeout: %0d results outstanding", pending_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Result side: random stalls, except during a hold-off or a clean stretch.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (recv_hold)
            rsp_ready <= 1'b0;
         else
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Send one transaction; valid stays up until accepted, with random gaps ahead.
   task automatic send_operands(input logic [15:0] a, input logic [15:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{operand_a: a, operand_b: b};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      if (a == 0 || b == 0) error_items++;
      @(negedge clock);
   endtask

   // Random operand with a spread of magnitudes, zero now and then, and
   // occasionally a multiple of a shared factor so gcd is not mostly 1.
   function automatic logic [15:0] pick_operand(input logic [15:0] factor);
      logic [15:0] v;
      int          sel;
      sel = $urandom_range(99);
      if (sel < 3)
         v = 16'd0;
      else if (sel < 40)
         v = 16'($urandom_range(1, 65535 / factor) * factor);
      else
         v = 16'($urandom) >> $urandom_range(15);
      return v;
   endfunction

   task automatic wait_drained();
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      logic [15:0] f;
      int          hold_cycles;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      sent_count = 0;
      error_items = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      recv_hold = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: zero operands, extremes, equal, swapped order, coprimes.
      send_operands(16'd0, 16'd0);
      send_operands(16'd0, 16'd7);
      send_operands(16'd9, 16'd0);
      send_operands(16'd1, 16'd1);
      send_operands(16'hFFFF, 16'hFFFF);
      send_operands(16'hFFFF, 16'hFFFE);
      send_operands(16'hFFFE, 16'hFFFF);
      send_operands(16'd1, 16'hFFFF);
      send_operands(16'h8000, 16'h8000);
      send_operands(16'h8000, 16'd1);
      send_operands(16'd12, 16'd18);
      send_operands(16'd18, 16'd12);
      send_operands(16'd1234, 16'd1234);
      send_operands(16'h5555, 16'hAAAA);
      send_operands(16'hAAAA, 16'h5555);
      send_operands(16'd65521, 16'd65519);
      send_operands(16'h8000, 16'h4000);
      send_operands(16'd46368, 16'd28657);
      req_valid <= 1'b0;

      // Sender pauses until every expected result is back.
      wait_drained();

      // Receiver holds off for a long stretch while requests keep coming.
      fork
         begin
            recv_hold = 1'b1;
            hold_cycles = 0;
            while (hold_cycles < 200) begin
               @(negedge clock);
               hold_cycles++;
            end
            recv_hold = 1'b0;
         end
         for (int i = 0; i < 120; i++)
            send_operands(16'($urandom), 16'($urandom));
      join
      req_valid <= 1'b0;

      // Random: first a stretch with no idling, then ~24% idling on both sides.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 300) begin
            send_idle_pct = 24;
            recv_idle_pct = 24;
         end
         f = 16'($urandom_range(1, 300));
         send_operands(pick_operand(f), pick_operand(f));
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (LATENCY + 10) @(negedge clock);

      $display("Sent %0d operand pairs (%0d with a zero operand), checked %0d results,",
               sent_count, error_items, result_count);
      $display("including a long output stall and a full drain pause.");
      if (fail_count == 0 && pending_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
